// ===== rtl/core/tps_pkg.sv =====
package tps_pkg;

   // Widths of the fields and of the search datapath
   localparam int RATE_W     = 10;
   localparam int RATE_IN_W  = 9;   // in-range rates fit below 512
   localparam int DIV_W      = 8;
   localparam int BASE_W     = 24;
   localparam int CODE_W     = 3;
   localparam int RELOAD_W   = 8;
   localparam int CNT_W      = 9;   // holds counts up to 256
   localparam int STEP_W     = RATE_IN_W + DIV_W;
   localparam int PROD_W     = STEP_W + CNT_W;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_ADDR_W = 3;

   localparam int NUM_DIV_REGS = 7;
   localparam int RATE_MAX     = 320;

   // Register indexes on the configuration port
   localparam logic [CSR_ADDR_W-1:0] REG_DIV_LAST = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_BASE     = 3'd7;

   localparam logic [DIV_W-1:0] DIV_RESET [NUM_DIV_REGS] =
      '{8'd4, 8'd10, 8'd16, 8'd50, 8'd64, 8'd100, 8'd200};
   localparam logic [BASE_W-1:0] BASE_RESET = 24'd2457600;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SEARCH,
      ST_FINISH
   } tps_state_type;

endpackage

// ===== rtl/core/timer_prescaler_search.sv =====
// Timer prescaler search.
// req channel: one beat carries the wanted interrupt rate in hertz.
// rsp channel: one beat per request carries found, control code and reload
// count (0 stands for 256) of the first divisor/count pair whose product
// with the rate lies closest to the programmed base clock.
// csr port: registers 0..6 are the divisors, register 7 the base clock;
// write only while no request is in flight.
// An in-range rate runs the search over every divisor and count before
// rsp_tvalid rises; a rate outside 1..320 skips the search and goes
// straight to a not-found result.
// The sequencer passes through a finish state and returns to idle before
// it takes the next request.
// One adder and one subtract/compare unit walk the candidates, one count
// per cycle, with a load step per divisor to form rate times divisor.
// req_tready is high only while the sequencer is idle; one request at a time.
// The result sits in an output register, so a new request is taken while
// it waits; a stalled receiver holds the finished search until it drains.
// Reset returns the sequencer to idle, drops rsp_tvalid and loads the
// register defaults.
module timer_prescaler_search #(
   parameter int NUM_DIVISORS = 7,
   parameter int MAX_COUNT    = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: [9:0] wanted_rate
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [tps_pkg::REQ_DATA_W-1:0]     req_tdata,
   // rsp_tdata: [0] found, [3:1] control_code, [11:4] reload_count
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [tps_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_we,
   input  logic [tps_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [tps_pkg::BASE_W-1:0]         csr_wdata
);

   tps_pkg::tps_state_type state_ff, state_in;

   logic [tps_pkg::DIV_W-1:0]     div_ff [tps_pkg::NUM_DIV_REGS];
   logic [tps_pkg::BASE_W-1:0]    base_ff;

   logic [tps_pkg::RATE_IN_W-1:0] rate_ff, rate_in;
   logic [tps_pkg::CODE_W-1:0]    idx_ff, idx_in;
   logic [tps_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [tps_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [tps_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic [tps_pkg::PROD_W-1:0]    best_diff_ff, best_diff_in;
   logic [tps_pkg::CODE_W-1:0]    best_code_ff, best_code_in;
   logic [tps_pkg::RELOAD_W-1:0]  best_count_ff, best_count_in;
   logic                          have_ff, have_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic [tps_pkg::CODE_W-1:0]    rsp_code_ff, rsp_code_in;
   logic [tps_pkg::RELOAD_W-1:0]  rsp_count_ff, rsp_count_in;

   logic [tps_pkg::RATE_W-1:0]    req_rate;
   logic                          rate_ok;
   logic                          req_fire;
   logic                          last_count;
   logic                          last_div;
   logic                          out_free;
   logic [tps_pkg::PROD_W-1:0]    base_ext;
   logic [tps_pkg::PROD_W-1:0]    diff;
   logic                          better;

   assign req_rate   = req_tdata[tps_pkg::RATE_W-1:0];
   assign rate_ok    = (req_rate != '0) &&
                       (req_rate <= tps_pkg::RATE_W'(tps_pkg::RATE_MAX));
   assign req_tready = (state_ff == tps_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign last_count = (count_ff == tps_pkg::CNT_W'(MAX_COUNT));
   assign last_div   = (idx_ff == tps_pkg::CODE_W'(NUM_DIVISORS - 1));
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Shared compare unit: distance of the current product from the base clock
   assign base_ext = tps_pkg::PROD_W'(base_ff);
   assign diff     = (prod_ff >= base_ext) ? (prod_ff - base_ext) : (base_ext - prod_ff);
   assign better   = !have_ff || (diff < best_diff_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tps_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = rate_ok ? tps_pkg::ST_LOAD : tps_pkg::ST_FINISH;
            end
         end
         tps_pkg::ST_LOAD: begin
            state_in = tps_pkg::ST_SEARCH;
         end
         tps_pkg::ST_SEARCH: begin
            if (last_count) begin
               state_in = last_div ? tps_pkg::ST_FINISH : tps_pkg::ST_LOAD;
            end
         end
         tps_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = tps_pkg::ST_IDLE;
            end
         end
         default: state_in = tps_pkg::ST_IDLE;
      endcase
   end

   // Datapath controls
   always_comb begin
      rate_in       = rate_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      prod_in       = prod_ff;
      best_diff_in  = best_diff_ff;
      best_code_in  = best_code_ff;
      best_count_in = best_count_ff;
      have_in       = have_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         tps_pkg::ST_IDLE: begin
            if (req_fire) begin
               rate_in       = req_rate[tps_pkg::RATE_IN_W-1:0];
               idx_in        = '0;
               have_in       = 1'b0;
               best_code_in  = '0;
               best_count_in = '0;
            end
         end
         tps_pkg::ST_LOAD: begin
            // form rate times divisor once; it is also the product at count one
            step_in  = tps_pkg::STEP_W'(rate_ff) * tps_pkg::STEP_W'(div_ff[idx_ff]);
            prod_in  = tps_pkg::PROD_W'(step_in);
            count_in = tps_pkg::CNT_W'(1);
         end
         tps_pkg::ST_SEARCH: begin
            // keep the first pair with the smallest distance
            if (better) begin
               have_in       = 1'b1;
               best_diff_in  = diff;
               best_code_in  = idx_ff + tps_pkg::CODE_W'(1);
               best_count_in = count_ff[tps_pkg::RELOAD_W-1:0];
            end
            count_in = count_ff + tps_pkg::CNT_W'(1);
            prod_in  = prod_ff + tps_pkg::PROD_W'(step_ff);
            if (last_count) begin
               idx_in = idx_ff + tps_pkg::CODE_W'(1);
            end
         end
         tps_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = have_ff;
               rsp_code_in  = best_code_ff;
               rsp_count_in = best_count_ff;
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tps_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Search and result registers
   always_ff @(posedge clock) begin
      rate_ff       <= rate_in;
      idx_ff        <= idx_in;
      count_ff      <= count_in;
      step_ff       <= step_in;
      prod_ff       <= prod_in;
      best_diff_ff  <= best_diff_in;
      best_code_ff  <= best_code_in;
      best_count_ff <= best_count_in;
      have_ff       <= have_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tps_pkg::NUM_DIV_REGS; i++) begin
            div_ff[i] <= tps_pkg::DIV_RESET[i];
         end
         base_ff <= tps_pkg::BASE_RESET;
      end else if (csr_we) begin
         if (csr_addr == tps_pkg::REG_BASE) begin
            base_ff <= csr_wdata;
         end else if (csr_addr <= tps_pkg::REG_DIV_LAST) begin
            div_ff[csr_addr] <= csr_wdata[tps_pkg::DIV_W-1:0];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_count_ff, rsp_code_ff, rsp_found_ff};

endmodule

// ===== rtl/core/tps_checker.sv =====
module tps_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [tps_pkg::REQ_DATA_W-1:0]  req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tps_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // A stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // No setting found means a zero code and count
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[11:1] == 11'd0)
      else $error("fields set on a not-found result");

   // A found setting always names a divisor
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[3:1] != 3'd0)
      else $error("found result with control code zero");

   // The search is busy in the cycle after a request is taken
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a search is running");

   // Padding bits stay low
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:12] == 4'd0)
      else $error("rsp padding not zero");

endmodule

bind timer_prescaler_search tps_checker u_tps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import tps_pkg::*;

   localparam int NUM_DIVISORS     = 7;
   localparam int MAX_COUNT        = 256;
   localparam int RESET_CYCLES     = 2;
   localparam int DIR_ROWS         = 20;
   localparam int RAND_PHASES      = 5;
   localparam int RAND_PER_PHASE   = 62;
   localparam int LONG_HOLD_AT     = 30;
   localparam int LONG_HOLD_CYCLES = 8000;
   localparam int TAIL_CYCLES      = 2000;
   localparam int WATCHDOG_LIMIT   = 40000;

   localparam logic [CSR_ADDR_W-1:0] REG_DIV_FIRST = '0;

   // Result beat, found in the lowest bit
   typedef struct packed {
      logic [RELOAD_W-1:0] reload;
      logic [CODE_W-1:0]   code;
      logic                found;
   } tps_result_t;

   typedef struct packed {
      logic [NUM_DIV_REGS-1:0][DIV_W-1:0] div;
      logic [BASE_W-1:0]                  base;
   } tps_cfg_t;

   typedef enum logic [2:0] {
      CFG_RESET,
      CFG_UNIT,
      CFG_ZERO,
      CFG_EXTREME,
      CFG_TOP,
      CFG_RANDOM
   } cfg_sel_e;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_SPARSE,
      RX_CYCLIC
   } stall_mode_e;

   typedef struct packed {
      cfg_sel_e           sel;
      logic [RATE_W-1:0]  rate;
      logic               typed;
      tps_result_t        res;
   } dir_row_t;

   localparam tps_result_t NONE      = '0;
   localparam tps_result_t HIT_FIRST = '{reload: 8'd1, code: 3'd1, found: 1'b1};

   // Directed rows; typed rows carry their own expectation
   localparam dir_row_t DIRECTED [DIR_ROWS] = '{
      '{CFG_RESET,   10'd0,    1'b1, NONE},
      '{CFG_RESET,   10'd1,    1'b0, NONE},
      '{CFG_RESET,   10'd320,  1'b0, NONE},
      '{CFG_RESET,   10'd321,  1'b1, NONE},
      '{CFG_RESET,   10'd1023, 1'b1, NONE},
      '{CFG_RESET,   10'd512,  1'b1, NONE},
      '{CFG_RESET,   10'd50,   1'b0, NONE},
      '{CFG_RESET,   10'd100,  1'b0, NONE},
      '{CFG_RESET,   10'd2,    1'b0, NONE},
      '{CFG_RESET,   10'd255,  1'b0, NONE},
      '{CFG_RESET,   10'd256,  1'b0, NONE},
      '{CFG_RESET,   10'd170,  1'b0, NONE},
      '{CFG_UNIT,    10'd1,    1'b1, HIT_FIRST},
      '{CFG_UNIT,    10'd320,  1'b1, HIT_FIRST},
      '{CFG_UNIT,    10'd0,    1'b1, NONE},
      '{CFG_EXTREME, 10'd320,  1'b0, NONE},
      '{CFG_EXTREME, 10'd1,    1'b0, NONE},
      '{CFG_EXTREME, 10'd321,  1'b1, NONE},
      '{CFG_ZERO,    10'd320,  1'b1, HIT_FIRST},
      '{CFG_ZERO,    10'd7,    1'b1, HIT_FIRST}
   };

   localparam cfg_sel_e RANDOM_PLAN [RAND_PHASES] =
      '{CFG_RANDOM, CFG_RESET, CFG_RANDOM, CFG_TOP, CFG_RANDOM};

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr   = '0;
   logic [BASE_W-1:0]      csr_wdata  = '0;

   tps_result_t awaited_q [$];
   tps_cfg_t    live_cfg;
   int          fault_count  = 0;
   int          results_seen = 0;
   int          burst_left   = 1;

   timer_prescaler_search #(
      .NUM_DIVISORS (NUM_DIVISORS),
      .MAX_COUNT    (MAX_COUNT)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Closest divisor/count pair; a later pair wins only when strictly closer
   function automatic tps_result_t best_setting(input logic [RATE_W-1:0] rate,
                                                input tps_cfg_t cfg);
      tps_result_t res;
      int unsigned step;
      int unsigned prod;
      int unsigned diff;
      int unsigned best_diff;
      bit          have;
      res       = NONE;
      have      = 1'b0;
      best_diff = 0;
      if (rate < 1 || rate > RATE_MAX)
         return res;
      for (int d = 0; d < NUM_DIVISORS; d++) begin
         step = 32'(rate) * 32'(cfg.div[d]);
         for (int c = 1; c <= MAX_COUNT; c++) begin
            prod = step * 32'(c);
            diff = (prod >= 32'(cfg.base)) ? prod - 32'(cfg.base) : 32'(cfg.base) - prod;
            if (!have || diff < best_diff) begin
               have       = 1'b1;
               best_diff  = diff;
               res.found  = 1'b1;
               res.code   = CODE_W'(d + 1);
               res.reload = RELOAD_W'(c);
            end
         end
      end
      return res;
   endfunction

   function automatic tps_cfg_t settings_of(input cfg_sel_e sel);
      tps_cfg_t cfg;
      cfg = '0;
      case (sel)
         CFG_RESET: begin
            for (int d = 0; d < NUM_DIV_REGS; d++)
               cfg.div[d] = DIV_RESET[d];
            cfg.base = BASE_RESET;
         end
         CFG_UNIT: begin
            for (int d = 0; d < NUM_DIV_REGS; d++)
               cfg.div[d] = 8'd1;
            cfg.base = 24'd1;
         end
         CFG_ZERO: begin
            cfg.base = '1;
         end
         CFG_EXTREME: begin
            cfg.div[0] = 8'd255;
            cfg.div[1] = 8'd0;
            cfg.div[2] = 8'd255;
            cfg.div[3] = 8'd1;
            cfg.div[4] = 8'd128;
            cfg.div[5] = 8'd200;
            cfg.div[6] = 8'd0;
            cfg.base   = '1;
         end
         CFG_TOP: begin
            for (int d = 0; d < NUM_DIV_REGS; d++)
               cfg.div[d] = 8'd200;
            cfg.base = '1;
         end
         default: begin
            for (int d = 0; d < NUM_DIV_REGS; d++)
               cfg.div[d] = DIV_W'($urandom_range(1, 200));
            if ($urandom_range(0, 1) == 0)
               cfg.base = BASE_W'($urandom_range(1, 16777215));
            else
               cfg.base = BASE_W'($urandom_range(100000, 4000000));
         end
      endcase
      return cfg;
   endfunction

   // Mostly in-range rates, the rest zero or above the limit
   function automatic logic [RATE_W-1:0] random_rate();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 80)
         return RATE_W'($urandom_range(1, RATE_MAX));
      else if (pick < 85)
         return '0;
      else
         return RATE_W'($urandom_range(RATE_MAX + 1, 1023));
   endfunction

   // Offer one rate and hold it until taken, then log what should come back
   task automatic offer_rate(input logic [RATE_W-1:0] rate, input logic typed,
                             input tps_result_t typed_res);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(rate);
      do
         @(posedge clock);
      while (req_tready !== 1'b1);
      awaited_q.push_back(typed ? typed_res : best_setting(rate, live_cfg));
   endtask

   // Bursts of random length, gaps from none up to longer than a search
   task automatic pace_sender();
      int gap;
      int pick;
      gap = 0;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 8);
         pick       = $urandom_range(0, 9);
         if (pick >= 8)
            gap = $urandom_range(200, 2500);
         else if (pick >= 4)
            gap = $urandom_range(1, 20);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering and wait for every outstanding result
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (awaited_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_settings(input tps_cfg_t cfg);
      for (int r = REG_DIV_FIRST; r <= REG_DIV_LAST; r++) begin
         csr_we    <= 1'b1;
         csr_addr  <= CSR_ADDR_W'(r);
         csr_wdata <= BASE_W'(cfg.div[r]);
         @(posedge clock);
      end
      csr_we    <= 1'b1;
      csr_addr  <= REG_BASE;
      csr_wdata <= cfg.base;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      live_cfg = cfg;
   endtask

   task automatic check_result(input tps_result_t got);
      tps_result_t want;
      results_seen++;
      if (awaited_q.size() == 0) begin
         $error("rsp beat with nothing outstanding: tdata %h", got);
         fault_count++;
         return;
      end
      want = awaited_q.pop_front();
      if (got.found !== want.found) begin
         $error("found: expected %0d, got %0d", want.found, got.found);
         fault_count++;
      end
      if (got.code !== want.code) begin
         $error("control_code: expected %0d, got %0d", want.code, got.code);
         fault_count++;
      end
      if (got.reload !== want.reload) begin
         $error("reload_count: expected %0d, got %0d", want.reload, got.reload);
         fault_count++;
      end
   endtask

   // Stimulus: directed table, then random phases under several settings
   initial begin
      cfg_sel_e cur_sel;
      live_cfg = settings_of(CFG_RESET);
      cur_sel  = CFG_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_ROWS; i++) begin
         if (DIRECTED[i].sel != cur_sel) begin
            settle_block();
            write_settings(settings_of(DIRECTED[i].sel));
            cur_sel = DIRECTED[i].sel;
         end
         offer_rate(DIRECTED[i].rate, DIRECTED[i].typed, DIRECTED[i].res);
         pace_sender();
      end

      for (int p = 0; p < RAND_PHASES; p++) begin
         settle_block();
         write_settings(settings_of(RANDOM_PLAN[p]));
         for (int n = 0; n < RAND_PER_PHASE; n++) begin
            offer_rate(random_rate(), 1'b0, NONE);
            pace_sender();
         end
      end

      settle_block();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Receiver: check each accepted beat, then pick the next ready level
   initial begin
      stall_mode_e mode;
      int          mode_left;
      int          tick;
      bit          long_hold_done;
      mode           = RX_OPEN;
      mode_left      = 0;
      tick           = 0;
      long_hold_done = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         tick++;
         if (rsp_tvalid === 1'b1 && rsp_tready)
            check_result(tps_result_t'(rsp_tdata[$bits(tps_result_t)-1:0]));
         if (!long_hold_done && results_seen == LONG_HOLD_AT) begin
            // hold off long enough for the block to back up onto its input
            long_hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            if (mode_left <= 0) begin
               mode      = stall_mode_e'($urandom_range(0, 3));
               mode_left = $urandom_range(10, 200);
            end
            mode_left--;
            case (mode)
               RX_OPEN:   rsp_tready <= 1'b1;
               RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_tready <= ($urandom_range(0, 7) == 0);
               default:   rsp_tready <= (tick % 3 != 0);
            endcase
         end
      end
   end

   // Watchdog on cycles without any accepted beat
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready)
             || reset)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== timer_prescaler_search.f =====
rtl/core/tps_pkg.sv
rtl/core/timer_prescaler_search.sv
rtl/core/tps_checker.sv
tb/sv/tb_top.sv
